FILE: rtl/upq_pkg.sv
// shared types and constants of the unique priority queue
`default_nettype none

package upq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned PRI_W    = 16;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned STAT_W   = 3;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_ENQUEUED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_DEQUEUED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load_req;
    logic              idx_from_count;
    logic              idx_dec;
    logic              pos_from_idx;
    logic              rd_en;
    logic              wr_shift;
    logic              wr_new;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              res_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_deq;
    logic cnt_zero;
    logic cnt_full;
    logic idx_zero;
    logic idx_eq_pos;
    logic cmp_eq;
    logic cmp_gt;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/upq_ctrl.sv
// sequencer of the unique priority queue
`default_nettype none

module upq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire upq_pkg::stat_t stat_i,
  output upq_pkg::cmd_t      cmd_o
);
  import upq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CMP = 3'd3;
  localparam logic [2:0] S_INS_CHK  = 3'd4;
  localparam logic [2:0] S_SH_RD    = 3'd5;
  localparam logic [2:0] S_SH_WR    = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req       = 1'b1;
          cmd_o.idx_from_count = 1'b1;
          state_d              = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_deq) begin
          cmd_o.set_status = 1'b1;
          if (stat_i.cnt_zero) begin
            cmd_o.status = ST_EMPTY;
          end else begin
            // top entry sits at count-1
            cmd_o.status  = ST_DEQUEUED;
            cmd_o.rd_en   = 1'b1;
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = S_RESP;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.idx_zero) begin
          state_d = S_INS_CHK;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat_i.cmp_eq) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DUPLICATE;
          state_d          = S_RESP;
        end else if (stat_i.cmp_gt) begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_SCAN_RD;
        end else begin
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (stat_i.cnt_full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_FULL;
          state_d          = S_RESP;
        end else begin
          cmd_o.pos_from_idx   = 1'b1;
          cmd_o.idx_from_count = 1'b1;
          state_d              = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.idx_eq_pos) begin
          cmd_o.wr_new     = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_ENQUEUED;
          state_d          = S_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
        state_d        = S_SH_RD;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/upq_dp.sv
// entry memory, index registers and result register of the queue
`default_nettype none

module upq_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_mode_i,
  input  wire logic [upq_pkg::PRI_W-1:0]  req_pri_i,
  input  wire logic [upq_pkg::TAG_W-1:0]  req_tag_i,
  input  wire upq_pkg::cmd_t              cmd_i,
  output upq_pkg::stat_t                  stat_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output logic [upq_pkg::STAT_W-1:0]      res_status_o,
  output logic [upq_pkg::PRI_W-1:0]       res_pri_o,
  output logic [upq_pkg::TAG_W-1:0]       res_tag_o
);
  import upq_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  logic              mode_q;
  logic [PRI_W-1:0]  pri_q;
  logic [TAG_W-1:0]  tag_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  pos_q;
  logic [CNT_W-1:0]  idx_m1;
  logic [STAT_W-1:0] status_q;
  logic              res_valid_q;
  logic [STAT_W-1:0] res_status_q;
  logic [PRI_W-1:0]  res_pri_q;
  logic [TAG_W-1:0]  res_tag_q;

  assign idx_m1 = idx_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= req_mode_i;
      pri_q  <= req_pri_i;
      tag_q  <= req_tag_i;
    end
    if (cmd_i.idx_from_count) begin
      idx_q <= cnt_q;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.pos_from_idx) begin
      pos_q <= idx_q;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  // single read port, registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_m1[ADDR_W-1:0]];
    end
    if (cmd_i.wr_shift) begin
      mem[idx_q[ADDR_W-1:0]] <= rdata_q;
    end else if (cmd_i.wr_new) begin
      mem[idx_q[ADDR_W-1:0]] <= '{tag: tag_q, pri: pri_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= status_q;
      if (status_q == ST_DEQUEUED) begin
        res_pri_q <= rdata_q.pri;
        res_tag_q <= rdata_q.tag;
      end else begin
        res_pri_q <= '0;
        res_tag_q <= '0;
      end
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_pri_o    = res_pri_q;
  assign res_tag_o    = res_tag_q;

  always_comb begin
    stat_o.is_deq     = (mode_q == MODE_DEQ);
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.cnt_full   = (cnt_q == CNT_W'(CAPACITY));
    stat_o.idx_zero   = (idx_q == '0);
    stat_o.idx_eq_pos = (idx_q == pos_q);
    stat_o.cmp_eq     = (rdata_q.pri == pri_q);
    stat_o.cmp_gt     = (rdata_q.pri > pri_q);
    stat_o.out_free   = !res_valid_q || res_ready_i;
  end

endmodule

`default_nettype wire

FILE: rtl/unique_priority_queue.sv
// top level of the sorted priority queue with distinct priorities
//
//   channel  dir  payload                                    done when
//   s_axis   in   tuser: mode, tdata: new_priority, new_tag  tvalid && tready
//   m_axis   out  tuser: status, tdata: out_priority, out_tag tvalid && tready
//
// one request at a time; every request gives one result
// a dequeue goes through dispatch to the result state; an enqueue scans down from
// the top, then shifts entries up and writes the new one; with m the number of
// held entries above the new priority, each is read once in the scan and once in
// the shift, one access a cycle through the single memory port
// a pending result waits in the output register; s_axis_tready rises again
// once it is loaded, so the next request is taken while the result is stalled
// reset empties the queue (entry count only, the memory is not cleared)
`default_nettype none

module unique_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [15:0] new_priority, [47:16] new_tag
  input  wire logic [0:0]  s_axis_tuser,  // [0] mode
  // result side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [15:0] out_priority, [47:16] out_tag
  output logic [2:0]       m_axis_tuser   // [2:0] status
);
  import upq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  req_ready;

  logic [PRI_W-1:0] res_pri;
  logic [TAG_W-1:0] res_tag;

  assign s_axis_tready = req_ready;

  // sequencer: scan, shift and result hand-off
  upq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // entry memory, count and result register
  upq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mode_i   (s_axis_tuser[0]),
    .req_pri_i    (s_axis_tdata[15:0]),
    .req_tag_i    (s_axis_tdata[47:16]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (m_axis_tuser),
    .res_pri_o    (res_pri),
    .res_tag_o    (res_tag)
  );

  // pack the result payload, priority in the low bits
  assign m_axis_tdata = {res_tag, res_pri};

endmodule

`default_nettype wire

FILE: dv/unique_priority_queue_test.sv
// self-checking stream testbench for the unique priority queue
`default_nettype none

module unique_priority_queue_test;
  import upq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;   // long output stall
  localparam int TAIL_CYCLES = 100;   // longer than the slowest enqueue

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRI_W-1:0]  pri;
    logic [TAG_W-1:0]  tag;
  } queue_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [15:0] new_priority, [47:16] new_tag
  logic [0:0]  s_axis_tuser = '0;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [15:0] out_priority, [47:16] out_tag
  logic [2:0]  m_axis_tuser;        // [2:0] status

  unique_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the sorted queue, ascending in slots 0 .. held_count-1
  logic [PRI_W-1:0] held_pri [CAPACITY];
  logic [TAG_W-1:0] held_tag [CAPACITY];
  int               held_count = 0;

  queue_result_t pending_results[$];
  int            status_seen [5] = '{default: 0};
  int            requests_sent = 0;
  int            mismatches = 0;

  // sender burst state
  int burst_left = 0;
  bit steady_sender = 1'b0;

  // long output stall, counted in its own process
  logic hold_go = 1'b0;
  int   hold_left = 0;

  function automatic queue_result_t apply_request(logic mode, logic [PRI_W-1:0] pri,
                                                  logic [TAG_W-1:0] tag);
    queue_result_t r;
    bit            dup;
    int            pos;
    r = '0;
    dup = 1'b0;
    if (mode == MODE_ENQ) begin
      for (int i = 0; i < held_count; i++) begin
        if (held_pri[i] == pri) dup = 1'b1;
      end
      // duplicate check wins over full
      if (dup) begin
        r.status = ST_DUPLICATE;
      end else if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = held_count;
        while (pos > 0 && held_pri[pos-1] > pri) begin
          held_pri[pos] = held_pri[pos-1];
          held_tag[pos] = held_tag[pos-1];
          pos--;
        end
        held_pri[pos] = pri;
        held_tag[pos] = tag;
        held_count++;
        r.status = ST_ENQUEUED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      held_count--;
      r.pri = held_pri[held_count];
      r.tag = held_tag[held_count];
      r.status = ST_DEQUEUED;
    end
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40) $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // offers one request and predicts its result once it is accepted
  task automatic send_request(logic mode, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag);
    int gap;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: gap = 0;
          1: gap = $urandom_range(1, 3);
          2: gap = $urandom_range(1, 20);
          default: gap = $urandom_range(20, 80);
        endcase
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {tag, pri};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(mode, pri, tag));
    requests_sent++;
  endtask

  // sender pauses until every result is back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_corner_cases();
    send_request(MODE_DEQ, 16'($urandom), $urandom);    // empty queue
    send_request(MODE_ENQ, 16'h0000, 32'h0000_0000);
    send_request(MODE_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(MODE_ENQ, 16'h8000, 32'hA5A5_5A5A);    // lands in the middle
    send_request(MODE_ENQ, 16'h8000, 32'h1234_5678);    // duplicate priority
    send_request(MODE_DEQ, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(MODE_DEQ, 16'h0000, 32'h0000_0000);
    send_request(MODE_DEQ, 16'($urandom), $urandom);
    send_request(MODE_DEQ, 16'($urandom), $urandom);    // empty again
    wait_all_results();
  endtask

  task automatic test_fill_to_capacity();
    logic [PRI_W-1:0] pris [CAPACITY];
    logic [PRI_W-1:0] extra;
    bit               clash;
    for (int i = 0; i < CAPACITY; i++) begin
      do begin
        pris[i] = 16'($urandom);
        clash = 1'b0;
        for (int j = 0; j < i; j++) if (pris[j] == pris[i]) clash = 1'b1;
      end while (clash);
      send_request(MODE_ENQ, pris[i], $urandom);
    end
    do begin
      extra = 16'($urandom);
      clash = 1'b0;
      for (int j = 0; j < CAPACITY; j++) if (pris[j] == extra) clash = 1'b1;
    end while (clash);
    send_request(MODE_ENQ, extra, $urandom);                          // full
    send_request(MODE_ENQ, pris[$urandom_range(0, CAPACITY-1)], $urandom); // dup while full
    wait_all_results();
  endtask

  // mixed traffic; the enqueue share and a narrow priority window change
  // every few dozen requests so the queue swings between empty and full
  task automatic test_random_traffic(int n_items);
    int               enq_pct;
    logic [PRI_W-1:0] base;
    logic [PRI_W-1:0] pri;
    logic             mode;
    enq_pct = 50;
    base = '0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 20;
          1: enq_pct = 50;
          2: enq_pct = 70;
          default: enq_pct = 95;
        endcase
        base = 16'($urandom_range(0, 65535 - 31));
      end
      mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      case ($urandom_range(0, 9))
        0: pri = 16'h0000;
        1: pri = 16'hFFFF;
        2, 3, 4, 5: pri = base + 16'($urandom_range(0, 31));
        default: pri = 16'($urandom);
      endcase
      send_request(mode, pri, $urandom);
    end
    wait_all_results();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_stalled_output();
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    steady_sender = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_request($urandom_range(0, 2) == 0 ? MODE_DEQ : MODE_ENQ,
                   16'($urandom_range(0, 63)), $urandom);
    end
    steady_sender = 1'b0;
    wait_all_results();
  endtask

  // repeated rounds of filling toward or past capacity and emptying past zero
  task automatic test_fill_and_empty(int rounds);
    int n;
    for (int r = 0; r < rounds; r++) begin
      n = $urandom_range(14, 20);
      for (int i = 0; i < n; i++) begin
        send_request(MODE_ENQ, ($urandom_range(0, 1) != 0) ? 16'($urandom) :
                     16'($urandom_range(0, 23)), $urandom);
      end
      for (int i = 0; i < n + 2; i++) send_request(MODE_DEQ, 16'($urandom), $urandom);
    end
    wait_all_results();
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_go) hold_left <= HOLD_CYCLES;
  end

  // result checker and receiver stall pattern
  logic [31:0] ready_pat = 32'hFFFF_FFFF;
  int          pat_age = 0;

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(m_axis_tuser), '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[15:0] !== want.pri)
          report_mismatch("out_priority", 32'(m_axis_tdata[15:0]), 32'(want.pri));
        if (m_axis_tdata[47:16] !== want.tag)
          report_mismatch("out_tag", m_axis_tdata[47:16], want.tag);
      end
    end
    if (pat_age == 200) begin
      pat_age <= 0;
      case ($urandom_range(0, 3))
        0: ready_pat <= 32'hFFFF_FFFF;
        1: ready_pat <= $urandom | $urandom;
        2: ready_pat <= $urandom;
        default: ready_pat <= $urandom & $urandom;
      endcase
    end else begin
      pat_age <= pat_age + 1;
      ready_pat <= {ready_pat[0], ready_pat[31:1]};
    end
    m_axis_tready <= (hold_left == 0) && ready_pat[0];
  end

  // watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout with %0d results pending", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_fill_to_capacity();
    test_random_traffic(800);
    test_stalled_output();
    test_fill_and_empty(10);
    test_random_traffic(460);

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", 32'(pending_results.size()), '0);

    $display("covered %0d requests: %0d enqueued, %0d duplicate, %0d full,",
             requests_sent, status_seen[ST_ENQUEUED], status_seen[ST_DUPLICATE],
             status_seen[ST_FULL]);
    $display("%0d dequeued, %0d empty; traffic included a long output stall",
             status_seen[ST_DEQUEUED], status_seen[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
